// ===== rtl/source_map_mappings_decoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// Source map mappings decoder: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SOURCE_MAP_MAPPINGS_DECODER_TOP_DEFINES_SVH
`define SOURCE_MAP_MAPPINGS_DECODER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMMD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMMD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/smmd_pkg.sv =====
// ----------------------------------------------------------------------------
// Source map mappings decoder package
// Transfer types, status codes, character classes and position arithmetic.
// ----------------------------------------------------------------------------
package smmd_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int DELTA_W         = 34;
    localparam int POS_W           = 32;
    localparam int NUM_FIELDS      = 5;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ST_RECORD   = 3'd0;
    localparam logic [2:0] ST_BADCHAR  = 3'd1;
    localparam logic [2:0] ST_UNTERM   = 3'd2;
    localparam logic [2:0] ST_FIELDS   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SEMI    = 8'h3B;

    localparam logic [5:0] DIG_LOWER_BASE = 6'd26;
    localparam logic [5:0] DIG_NUM_BASE   = 6'd52;
    localparam logic [5:0] DIG_PLUS       = 6'd62;
    localparam logic [5:0] DIG_SLASH      = 6'd63;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } item_t;

    typedef struct packed {
        logic [2:0]               status;
        logic signed [POS_W-1:0]  gen_line;
        logic signed [POS_W-1:0]  gen_column;
        logic signed [POS_W-1:0]  source_index;
        logic signed [POS_W-1:0]  orig_line;
        logic signed [POS_W-1:0]  orig_column;
        logic signed [POS_W-1:0]  name_index;
        logic                     has_name;
    } result_t;

    typedef struct packed {
        logic       step;
        logic       close;
        logic       digit_ok;
        logic [5:0] digit;
        logic       comma;
        logic       semi;
        logic       bad;
        logic       last;
    } chr_t;

    typedef struct packed {
        logic                     big;
        logic signed [DELTA_W-1:0] d;
    } delta_t;

    typedef struct packed {
        logic   fin;
        logic   ovf;
        logic   open_post;
        delta_t delta;
    } vlq_t;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] val;
    } pos_res_t;

    function automatic chr_t classify(input item_t it);
        chr_t       r;
        logic [7:0] c;
        r      = '0;
        c      = it.char_code;
        r.last = it.last;
        priority if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            r.digit_ok = 1'b1;
            r.digit    = 6'(c - CH_UPPER_A);
        end
        else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
        begin
            r.digit_ok = 1'b1;
            r.digit    = 6'(c - CH_LOWER_A) + DIG_LOWER_BASE;
        end
        else if (c >= CH_ZERO && c <= CH_NINE)
        begin
            r.digit_ok = 1'b1;
            r.digit    = 6'(c - CH_ZERO) + DIG_NUM_BASE;
        end
        else if (c == CH_PLUS)
        begin
            r.digit_ok = 1'b1;
            r.digit    = DIG_PLUS;
        end
        else if (c == CH_SLASH)
        begin
            r.digit_ok = 1'b1;
            r.digit    = DIG_SLASH;
        end
        else if (c == CH_COMMA)
        begin
            r.comma = 1'b1;
        end
        else if (c == CH_SEMI)
        begin
            r.semi = 1'b1;
        end
        else
        begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    // Adds a delta to a position; fails when the delta or the sum leaves range.
    function automatic pos_res_t add_pos(input logic [POS_W-1:0] pos, input delta_t dl);
        pos_res_t           r;
        logic [POS_W+2:0]   s;
        s     = {{3{pos[POS_W-1]}}, pos} + {dl.d[DELTA_W-1], dl.d};
        r.ok  = !dl.big && ((s[POS_W+2:POS_W-1] == '0) || (s[POS_W+2:POS_W-1] == '1));
        r.val = s[POS_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/smmd_vlq.sv =====
// ----------------------------------------------------------------------------
// Source map mappings decoder: VLQ value accumulator
// Gathers base64 digits into one signed value and flags digits beyond range.
// ----------------------------------------------------------------------------
module smmd_vlq #(
    parameter int VALUE_WIDTH = smmd_pkg::VALUE_WIDTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  smmd_pkg::chr_t  chr,
    input  logic            seg_err,
    output smmd_pkg::vlq_t  vlq
);

    localparam int SHW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] acc_reg, acc_next, acc_or;
    logic [SHW-1:0]         shift_reg, shift_next, shift_clamp;
    logic                   open_reg, open_next;
    logic [SHW:0]           shift_sum;
    logic [4:0]             low;
    logic                   cont, en, ovf;
    logic [VALUE_WIDTH-2:0] mag;
    logic [64:0]            mag_x;
    logic [smmd_pkg::DELTA_W-1:0] dmag;

    assign low  = chr.digit[4:0];
    assign cont = chr.digit[5];
    assign en   = chr.step && chr.digit_ok && !seg_err;

    always_comb
    begin
        ovf = 1'b0;
        for (int i = 0; i < 5; i++)
        begin
            if (low[i] && (({1'b0, shift_reg} + (SHW+1)'(i)) >= (SHW+1)'(VALUE_WIDTH)))
            begin
                ovf = 1'b1;
            end
        end
        ovf = ovf && en;
    end

    assign acc_or    = acc_reg | (VALUE_WIDTH'(low) << shift_reg);
    assign shift_sum = {1'b0, shift_reg} + (SHW+1)'(5);
    assign shift_clamp = (shift_sum > (SHW+1)'(VALUE_WIDTH)) ? SHW'(VALUE_WIDTH)
                                                             : shift_sum[SHW-1:0];

    assign mag   = acc_or[VALUE_WIDTH-1:1];
    assign mag_x = 65'(mag);
    assign dmag  = mag_x[smmd_pkg::DELTA_W-1:0];

    always_comb
    begin
        vlq.ovf       = ovf;
        vlq.fin       = en && !ovf && !cont;
        vlq.open_post = (en && !ovf) ? cont : open_reg;
        vlq.delta.big = mag_x > 65'h1_0000_0000;
        vlq.delta.d   = acc_or[0] ? -dmag : dmag;
    end

    always_comb
    begin
        acc_next   = acc_reg;
        shift_next = shift_reg;
        open_next  = open_reg;
        if (chr.step)
        begin
            if (chr.close)
            begin
                acc_next   = '0;
                shift_next = '0;
                open_next  = 1'b0;
            end
            else if (en && !ovf)
            begin
                acc_next   = cont ? acc_or : '0;
                shift_next = cont ? shift_clamp : '0;
                open_next  = cont;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            shift_reg <= '0;
            open_reg  <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            shift_reg <= shift_next;
            open_reg  <= open_next;
        end
    end

endmodule

// ===== rtl/smmd_segment.sv =====
// ----------------------------------------------------------------------------
// Source map mappings decoder: segment tracker
// Collects field deltas, closes segments and keeps the absolute position.
// ----------------------------------------------------------------------------
module smmd_segment (
    input  logic                clk,
    input  logic                rst_n,
    input  smmd_pkg::chr_t      chr,
    input  smmd_pkg::vlq_t      vlq,
    output logic                seg_err,
    output logic                emit,
    output smmd_pkg::result_t   res
);

    localparam int NF = smmd_pkg::NUM_FIELDS;
    localparam int PW = smmd_pkg::POS_W;

    logic [2:0]       fc_reg, fc_next, fc_post;
    logic [2:0]       err_reg, err_next, err_post;
    smmd_pkg::delta_t pend_reg [NF];
    smmd_pkg::delta_t pend_next [NF];
    smmd_pkg::delta_t pend_post [NF];
    logic [PW-1:0]    gl_reg, gc_reg, src_reg, ol_reg, oc_reg, nm_reg;
    logic [PW-1:0]    gl_next, gc_next, src_next, ol_next, oc_next, nm_next;
    smmd_pkg::pos_res_t a_gc, a_src, a_ol, a_oc, a_nm;
    logic [2:0]       code;
    logic             upd_col, upd_all, rec;

    assign seg_err = (err_reg != smmd_pkg::ERR_NONE);

    always_comb
    begin
        err_post = err_reg;
        if (err_reg == smmd_pkg::ERR_NONE)
        begin
            priority if (chr.bad)
            begin
                err_post = smmd_pkg::ST_BADCHAR;
            end
            else if (vlq.ovf)
            begin
                err_post = smmd_pkg::ST_OVERFLOW;
            end
        end
        fc_post = (vlq.fin && fc_reg != 3'd6) ? fc_reg + 3'd1 : fc_reg;
        for (int i = 0; i < NF; i++)
        begin
            pend_post[i] = (vlq.fin && fc_reg == 3'(i)) ? vlq.delta : pend_reg[i];
        end
    end

    assign a_gc  = smmd_pkg::add_pos(gc_reg,  pend_post[0]);
    assign a_src = smmd_pkg::add_pos(src_reg, pend_post[1]);
    assign a_ol  = smmd_pkg::add_pos(ol_reg,  pend_post[2]);
    assign a_oc  = smmd_pkg::add_pos(oc_reg,  pend_post[3]);
    assign a_nm  = smmd_pkg::add_pos(nm_reg,  pend_post[4]);

    always_comb
    begin
        code    = err_post;
        upd_col = 1'b0;
        upd_all = 1'b0;
        rec     = 1'b0;
        if (code == smmd_pkg::ERR_NONE && vlq.open_post)
        begin
            code = smmd_pkg::ST_UNTERM;
        end
        if (code == smmd_pkg::ERR_NONE)
        begin
            unique case (fc_post)
                3'd0:
                begin
                    if (chr.comma)
                    begin
                        code = smmd_pkg::ST_FIELDS;
                    end
                end
                3'd1:
                begin
                    if (a_gc.ok)
                    begin
                        upd_col = 1'b1;
                    end
                    else
                    begin
                        code = smmd_pkg::ST_OVERFLOW;
                    end
                end
                3'd4, 3'd5:
                begin
                    if (a_gc.ok && a_src.ok && a_ol.ok && a_oc.ok
                        && (fc_post != 3'd5 || a_nm.ok))
                    begin
                        upd_all = 1'b1;
                        rec     = 1'b1;
                    end
                    else
                    begin
                        code = smmd_pkg::ST_OVERFLOW;
                    end
                end
                default:
                begin
                    code = smmd_pkg::ST_FIELDS;
                end
            endcase
        end

        emit = chr.close && (rec || code != smmd_pkg::ERR_NONE);
        res  = '0;
        if (rec)
        begin
            res.status       = smmd_pkg::ST_RECORD;
            res.gen_line     = gl_reg;
            res.gen_column   = a_gc.val;
            res.source_index = a_src.val;
            res.orig_line    = a_ol.val;
            res.orig_column  = a_oc.val;
            res.name_index   = (fc_post == 3'd5) ? a_nm.val : nm_reg;
            res.has_name     = (fc_post == 3'd5);
        end
        else
        begin
            res.status = code;
        end
    end

    always_comb
    begin
        fc_next  = fc_reg;
        err_next = err_reg;
        gl_next  = gl_reg;
        gc_next  = gc_reg;
        src_next = src_reg;
        ol_next  = ol_reg;
        oc_next  = oc_reg;
        nm_next  = nm_reg;
        for (int i = 0; i < NF; i++)
        begin
            pend_next[i] = pend_reg[i];
        end
        if (chr.step)
        begin
            if (chr.close)
            begin
                fc_next  = '0;
                err_next = smmd_pkg::ERR_NONE;
                for (int i = 0; i < NF; i++)
                begin
                    pend_next[i] = '0;
                end
                if (upd_col || upd_all)
                begin
                    gc_next = a_gc.val;
                end
                if (upd_all)
                begin
                    src_next = a_src.val;
                    ol_next  = a_ol.val;
                    oc_next  = a_oc.val;
                    if (fc_post == 3'd5)
                    begin
                        nm_next = a_nm.val;
                    end
                end
                if (chr.semi)
                begin
                    gl_next = gl_reg + PW'(1);
                    gc_next = '0;
                end
            end
            else
            begin
                fc_next  = fc_post;
                err_next = err_post;
                for (int i = 0; i < NF; i++)
                begin
                    pend_next[i] = pend_post[i];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg  <= '0;
            err_reg <= smmd_pkg::ERR_NONE;
            gl_reg  <= '0;
            gc_reg  <= '0;
            src_reg <= '0;
            ol_reg  <= '0;
            oc_reg  <= '0;
            nm_reg  <= '0;
            for (int i = 0; i < NF; i++)
            begin
                pend_reg[i] <= '0;
            end
        end
        else
        begin
            fc_reg  <= fc_next;
            err_reg <= err_next;
            gl_reg  <= gl_next;
            gc_reg  <= gc_next;
            src_reg <= src_next;
            ol_reg  <= ol_next;
            oc_reg  <= oc_next;
            nm_reg  <= nm_next;
            for (int i = 0; i < NF; i++)
            begin
                pend_reg[i] <= pend_next[i];
            end
        end
    end

endmodule

// ===== rtl/source_map_mappings_decoder_top.sv =====
// Characters pass the input register; a segment close fills the result register.
// One character per cycle unless stalled; a segment close gives at most one result.
// A stalled result holds the input register, so intake stops once it holds a character.
// Reset: rst_n clears all positions, the open segment and both valid flags at once.
// ----------------------------------------------------------------------------
// Source map mappings decoder top level
// Decodes base64 VLQ mappings characters into position records and error codes.
// ----------------------------------------------------------------------------
`include "source_map_mappings_decoder_top_defines.svh"

module source_map_mappings_decoder_top #(
    parameter int VALUE_WIDTH = smmd_pkg::VALUE_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  smmd_pkg::item_t    item,
    output logic               result_valid,
    input  logic               result_stall,
    output smmd_pkg::result_t  result
);

    logic               s1_valid_reg, s1_valid_next;
    smmd_pkg::item_t    s1_data_reg;
    logic               out_valid_reg, out_valid_next;
    smmd_pkg::result_t  out_data_reg;
    logic               advance, take;
    smmd_pkg::chr_t     chr;
    smmd_pkg::vlq_t     vlq;
    smmd_pkg::result_t  seg_res;
    logic               seg_emit, seg_err;

    assign advance    = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !advance;
    assign take       = item_valid && !item_stall;

    always_comb
    begin
        chr       = smmd_pkg::classify(s1_data_reg);
        chr.step  = advance;
        chr.close = advance && (chr.comma || chr.semi || chr.last);
    end

    smmd_vlq #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_vlq (
        .clk     (clk),
        .rst_n   (rst_n),
        .chr     (chr),
        .seg_err (seg_err),
        .vlq     (vlq)
    );

    smmd_segment u_segment (
        .clk     (clk),
        .rst_n   (rst_n),
        .chr     (chr),
        .vlq     (vlq),
        .seg_err (seg_err),
        .emit    (seg_emit),
        .res     (seg_res)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = seg_emit;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_data_reg <= item;
        end
        if (advance && seg_emit)
        begin
            out_data_reg <= seg_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    `SMMD_ASSERT_SAME(a_err_zero,
        result_valid && result.status != smmd_pkg::ST_RECORD,
        result.gen_line == 0 && result.gen_column == 0 && result.source_index == 0
            && result.orig_line == 0 && result.orig_column == 0
            && result.name_index == 0 && !result.has_name,
        "error result carries nonzero fields")
    `SMMD_ASSERT_SAME(a_status_range, result_valid,
        result.status <= smmd_pkg::ST_OVERFLOW, "result status out of range")
    `SMMD_ASSERT_SAME(a_stall_full, item_stall,
        s1_valid_reg && out_valid_reg, "input stalled while a stage is free")
    `SMMD_ASSERT_NEXT(a_emit_shown, advance && seg_emit,
        result_valid, "emitted result was lost")

endmodule
